// File: rtl/core/mavf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average filter package
// Widths, shared types and controller states for the moving average filter.
// ----------------------------------------------------------------------------
package mavf_pkg;

    localparam int MAX_WINDOW  = 256;
    localparam int SAMPLE_W    = 16;
    localparam int PTR_W       = $clog2(MAX_WINDOW);
    localparam int LEN_W       = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W       = SAMPLE_W + PTR_W + 1;
    localparam int CNT_W       = $clog2(SUM_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int LEN_RESET   = 8;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic [LEN_W-1:0]           len_t;

    typedef struct packed {
        sum_t sum;
        len_t len;
    } mavf_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } mavf_queue_status_t;

    typedef enum logic {
        FE_IDLE,
        FE_UPDATE
    } fe_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } bk_state_t;

endpackage

// File: rtl/core/moving_average_filter.sv
`timescale 1ns / 1ps
// The bit-serial divider pops a job, works out its quotient, then loads the
// output register once that is free, and pops the next job only after that.
// The front end takes a new sample only after it has queued the last one's
// job (registered window store read) and runs ahead of the divider by up to
// two queued jobs.
// Reset (synchronous, active low) and a window_length write clear the window.
// ----------------------------------------------------------------------------
// Moving average filter
// Mean of the most recent window_length signed samples, truncated toward zero.
// ----------------------------------------------------------------------------
module moving_average_filter (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mavf_pkg::LEN_W-1:0]  cfg_window_length,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  mavf_pkg::sample_t           s_sample,
    output logic                        m_valid,
    input  logic                        m_ready,
    output mavf_pkg::sample_t           m_average
);
    import mavf_pkg::*;

    mavf_queue_status_t  q_status;
    mavf_job_t           push_job;
    mavf_job_t           head_job;
    logic                push;
    logic                pop;

    assign cfg_ready = 1'b1;

    mavf_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_window_length (cfg_window_length),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_sample          (s_sample),
        .q_status          (q_status),
        .push              (push),
        .job               (push_job)
    );

    mavf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    mavf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_job  (head_job),
        .q_status  (q_status),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_average (m_average)
    );

endmodule

// File: rtl/core/mavf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average filter front end
// Accepts samples, keeps the window store, write pointer and running sum,
// and queues one division job per sample.
// ----------------------------------------------------------------------------
module mavf_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [mavf_pkg::LEN_W-1:0]    cfg_window_length,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  mavf_pkg::sample_t             s_sample,
    input  mavf_pkg::mavf_queue_status_t  q_status,
    output logic                          push,
    output mavf_pkg::mavf_job_t           job
);
    import mavf_pkg::*;

    fe_state_t            state_reg, state_next;
    len_t                 len_reg;
    len_t                 len_eff;
    len_t                 len_m1;
    logic [PTR_W-1:0]     wp_reg;
    logic                 wrapped_reg;
    sum_t                 sum_reg;
    sum_t                 sum_next;
    sample_t              sample_reg;
    sample_t              rd_data_reg;
    sample_t              old_sample;
    sample_t              mem [MAX_WINDOW];
    logic                 accept;

    always_comb begin
        if (cfg_window_length == '0) begin
            len_eff = LEN_W'(1);
        end else if (cfg_window_length > LEN_W'(MAX_WINDOW)) begin
            len_eff = LEN_W'(MAX_WINDOW);
        end else begin
            len_eff = cfg_window_length;
        end
    end

    assign len_m1     = len_reg - LEN_W'(1);
    assign accept     = s_valid && s_ready;
    assign old_sample = wrapped_reg ? rd_data_reg : '0;
    assign sum_next   = sum_reg
                      + {{(SUM_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg}
                      - {{(SUM_W-SAMPLE_W){old_sample[SAMPLE_W-1]}}, old_sample};

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        push       = 1'b0;
        case (state_reg)
            FE_IDLE: begin
                s_ready = !q_status.full;
                if (s_valid && !q_status.full) begin
                    state_next = FE_UPDATE;
                end
            end
            FE_UPDATE: begin
                push       = 1'b1;
                state_next = FE_IDLE;
            end
            default: begin
                state_next = FE_IDLE;
            end
        endcase
    end

    assign job.sum = sum_next;
    assign job.len = len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FE_IDLE;
            len_reg     <= LEN_W'(LEN_RESET);
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
            sum_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                len_reg     <= len_eff;
                wp_reg      <= '0;
                wrapped_reg <= 1'b0;
                sum_reg     <= '0;
            end else if (push) begin
                sum_reg <= sum_next;
                if (wp_reg == len_m1[PTR_W-1:0]) begin
                    wp_reg      <= '0;
                    wrapped_reg <= 1'b1;
                end else begin
                    wp_reg <= wp_reg + PTR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg  <= s_sample;
            rd_data_reg <= mem[wp_reg];
        end
        if (push) begin
            mem[wp_reg] <= sample_reg;
        end
    end

endmodule

// File: rtl/core/mavf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average filter job queue
// Short first-in first-out buffer between the front end and the divider.
// ----------------------------------------------------------------------------
module mavf_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  mavf_pkg::mavf_job_t           push_job,
    input  logic                          pop,
    output mavf_pkg::mavf_job_t           head_job,
    output mavf_pkg::mavf_queue_status_t  status
);
    import mavf_pkg::*;

    mavf_job_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign head_job     = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/core/mavf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average filter divider back end
// Divides each queued running sum by its window length, one quotient bit a
// cycle, truncating toward zero, and holds the result in an output register.
// ----------------------------------------------------------------------------
module mavf_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mavf_pkg::mavf_job_t           head_job,
    input  mavf_pkg::mavf_queue_status_t  q_status,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output mavf_pkg::sample_t             m_average
);
    import mavf_pkg::*;

    bk_state_t          state_reg, state_next;
    logic [SUM_W-1:0]   quo_reg;
    logic [LEN_W-1:0]   rem_reg;
    len_t               len_reg;
    logic               neg_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [LEN_W:0]     rem_shift;
    logic               fits;
    logic [SUM_W-1:0]   abs_sum;
    logic [SUM_W-1:0]   signed_quo;
    logic               out_valid_reg;
    sample_t            out_reg;
    logic               load_out;

    assign abs_sum    = head_job.sum[SUM_W-1] ? SUM_W'(-head_job.sum) : SUM_W'(head_job.sum);
    assign rem_shift  = {rem_reg, quo_reg[SUM_W-1]};
    assign fits       = (rem_shift >= {1'b0, len_reg});
    assign signed_quo = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (!q_status.empty) begin
                    pop        = 1'b1;
                    state_next = BK_DIV;
                end
            end
            BK_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (pop) begin
                cnt_reg <= CNT_W'(SUM_W - 1);
            end else if (state_reg == BK_DIV) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            quo_reg <= abs_sum;
            rem_reg <= '0;
            len_reg <= head_job.len;
            neg_reg <= head_job.sum[SUM_W-1];
        end else if (state_reg == BK_DIV) begin
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? LEN_W'(rem_shift - {1'b0, len_reg}) : rem_shift[LEN_W-1:0];
        end
        if (load_out) begin
            out_reg <= signed_quo[SAMPLE_W-1:0];
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_average = out_reg;

endmodule
